[hw/rtl/rta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg
// Types, codes and constants shared by the task admission block.
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int ADDR_W      = 4;
    localparam int NRW         = 4;
    localparam int MAX_RESULTS = 10;
    localparam int COST_W      = 37;
    localparam int SUM_W       = 8;

    // register indexes
    localparam logic [1:0] REG_MEM_CAP = 2'd0;
    localparam logic [1:0] REG_CU_CAP  = 2'd1;
    localparam logic [1:0] REG_XFER    = 2'd2;

    localparam logic [19:0] MEM_CAP_RST = 20'hFFFFF;
    localparam logic [7:0]  CU_CAP_RST  = 8'd8;
    localparam logic [15:0] XFER_RST    = 16'd1;

    // request modes
    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_FINISH  = 3'd1;
    localparam logic [2:0] MODE_PREEMPT = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_REMOVE  = 3'd4;
    localparam logic [2:0] MODE_STATUS  = 3'd5;

    // result kinds
    localparam logic [3:0] KIND_REJECTED = 4'd0;
    localparam logic [3:0] KIND_QUEUED   = 4'd1;
    localparam logic [3:0] KIND_STARTED  = 4'd2;
    localparam logic [3:0] KIND_FINISHED = 4'd3;
    localparam logic [3:0] KIND_EVICTED  = 4'd4;
    localparam logic [3:0] KIND_REMOVED  = 4'd5;
    localparam logic [3:0] KIND_NOTFOUND = 4'd6;
    localparam logic [3:0] KIND_CLEARED  = 4'd7;
    localparam logic [3:0] KIND_STATUS   = 4'd8;
    localparam logic [3:0] KIND_FULL     = 4'd9;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] task_id;
        logic [19:0] data_size;
        logic [7:0]  compute_units;
        logic [31:0] duration;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] result_task;
        logic [19:0] free_memory;
        logic [7:0]  free_compute;
        logic [4:0]  pending_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0]       ident;
        logic [19:0]       memory;
        logic [7:0]        units;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef struct packed {
        logic      push;
        logic      flush;
        out_word_t word;
    } emit_ctl_t;

    typedef struct packed {
        logic ack;
    } emit_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_MUL,
        S_ADD_DEC,
        S_RSCAN_RD,
        S_RSCAN_CK,
        S_HEAD_RD,
        S_HEAD_CK,
        S_QSCAN_RD,
        S_QSCAN_CK,
        S_PRE_CHK,
        S_MAX_RD,
        S_MAX_CK,
        S_EVICT,
        S_DROP_RD,
        S_DROP_WR,
        S_EMIT,
        S_FLUSH
    } state_t;

endpackage

[hw/rtl/rta_result.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_result
// Result staging: holds the newest word back until the next one or the end
// of the request shows whether it is the last, then drives the output register.
// ----------------------------------------------------------------------------
module rta_result
    import rta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_ctl_t  ctl,
    output emit_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data
);

    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;
    logic      pend_valid_reg, pend_valid_next;
    out_word_t pend_reg, pend_next;
    logic      can_emit, push_ok, flush_ok, load_out;

    always_comb
    begin
        can_emit = !out_valid_reg || out_ready;
        push_ok  = ctl.push && (!pend_valid_reg || can_emit);
        flush_ok = ctl.flush && can_emit;
        load_out = (push_ok && pend_valid_reg) || flush_ok;

        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_data_next      = pend_reg;
            out_data_next.last = flush_ok;
        end
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (push_ok)
            pend_valid_next = 1'b1;
        else if (flush_ok)
            pend_valid_next = 1'b0;
        else
            pend_valid_next = pend_valid_reg;
        pend_next = push_ok ? ctl.word : pend_reg;
        stat.ack  = push_ok || flush_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pend_reg     <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hw/rtl/resource_aware_task_admission.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_aware_task_admission
// Admits tasks against memory and compute capacities, with a FIFO wait queue.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only between requests.
// Running tasks live in a RUN_SLOTS-entry table and waiting tasks in a
// QUEUE_DEPTH-entry queue, both synchronous memories with one write and one
// registered read, so every search walks its memory one entry at a time, a
// read state and then a check state per entry. An add multiplies, decides
// and emits; finish, preempt and remove search their memory, shift each queue
// entry behind one that leaves the queue, and scan the run table for each
// eviction. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module resource_aware_task_admission
    import rta_pkg::*;
#(
    parameter int RUN_SLOTS   = 8,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int RIW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int RCW = $clog2(RUN_SLOTS + 1);
    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [19:0] mem_cap_reg;
    logic [7:0]  cu_cap_reg;
    logic [15:0] xfer_reg;
    logic        apb_wr;
    logic [1:0]  apb_idx;

    // state
    state_t                 state_reg, state_next, ret_reg, ret_next;
    in_word_t               req_reg, req_next;
    logic [35:0]            prod_reg, prod_next;
    logic [19:0]            mem_used_reg, mem_used_next;
    logic [7:0]             units_used_reg, units_used_next;
    logic [QCW-1:0]         wc_reg, wc_next;
    logic [RCW-1:0]         rc_reg, rc_next;
    logic [RUN_SLOTS-1:0]   run_valid_reg, run_valid_next;
    logic [NRW-1:0]         nres_reg, nres_next;
    logic [RCW-1:0]         ridx_reg, ridx_next;
    logic [QCW-1:0]         qidx_reg, qidx_next;
    entry_t                 cand_reg, cand_next, best_reg, best_next;
    logic [RIW-1:0]         best_idx_reg, best_idx_next;
    logic                   best_found_reg, best_found_next;
    logic [3:0]             em_kind_reg, em_kind_next;
    logic [15:0]            em_task_reg, em_task_next;

    // memories
    entry_t rt_mem [RUN_SLOTS];
    entry_t wq_mem [QUEUE_DEPTH];
    entry_t rt_rdata, wq_rdata, rt_wdata, wq_wdata;
    logic   rt_we, wq_we;
    logic [RIW-1:0] rt_waddr;
    logic [QIW-1:0] wq_waddr, wq_raddr;

    // decisions
    logic           free_found;
    logic [RIW-1:0] free_idx;
    logic [COST_W-1:0] add_cost;
    logic add_bad, add_start, q_full, fin_hit, q_hit, head_fits;
    logic cand_over, cand_fits, need_evict, better, res_full, drop_more;
    logic [QCW:0]   drop_nxt;

    emit_ctl_t  em_ctl;
    emit_stat_t em_stat;

    function automatic logic fits(input logic [19:0] used_m, input logic [7:0] used_u,
                                  input logic [19:0] cap_m, input logic [7:0] cap_u,
                                  input logic [19:0] m, input logic [7:0] u);
        fits = ({1'b0, used_m} + {1'b0, m} <= {1'b0, cap_m}) &&
               ({1'b0, used_u} + {1'b0, u} <= {1'b0, cap_u});
    endfunction

    // ---------------- configuration port ----------------
    assign apb_wr  = psel && penable && pwrite;
    assign apb_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (apb_idx)
            REG_MEM_CAP: prdata = {12'd0, mem_cap_reg};
            REG_CU_CAP:  prdata = {24'd0, cu_cap_reg};
            REG_XFER:    prdata = {16'd0, xfer_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_cap_reg <= MEM_CAP_RST;
            cu_cap_reg  <= CU_CAP_RST;
            xfer_reg    <= XFER_RST;
        end
        else if (apb_wr)
        begin
            unique case (apb_idx)
                REG_MEM_CAP: mem_cap_reg <= pwdata[19:0];
                REG_CU_CAP:  cu_cap_reg  <= pwdata[7:0];
                REG_XFER:    xfer_reg    <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // ---------------- shared decisions ----------------
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = RUN_SLOTS - 1; i >= 0; i--)
        begin
            if (!run_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = RIW'(i);
            end
        end
    end

    assign add_cost  = COST_W'(req_reg.duration) + COST_W'(prod_reg);
    assign add_bad   = (req_reg.data_size == 20'd0) || (req_reg.compute_units == 8'd0) ||
                       (req_reg.data_size > mem_cap_reg) ||
                       (req_reg.compute_units > cu_cap_reg);
    assign add_start = (wc_reg == '0) && free_found &&
                       fits(mem_used_reg, units_used_reg, mem_cap_reg, cu_cap_reg,
                            req_reg.data_size, req_reg.compute_units);
    assign q_full    = (wc_reg == QCW'(QUEUE_DEPTH));
    assign fin_hit   = run_valid_reg[ridx_reg[RIW-1:0]] && (rt_rdata.ident == req_reg.task_id);
    assign q_hit     = (wq_rdata.ident == req_reg.task_id);
    assign head_fits = fits(mem_used_reg, units_used_reg, mem_cap_reg, cu_cap_reg,
                            wq_rdata.memory, wq_rdata.units);
    assign cand_over = (cand_reg.memory > mem_cap_reg) || (cand_reg.units > cu_cap_reg);
    assign cand_fits = fits(mem_used_reg, units_used_reg, mem_cap_reg, cu_cap_reg,
                            cand_reg.memory, cand_reg.units);
    assign need_evict = (!cand_fits || !free_found) && (rc_reg != '0);
    assign better    = run_valid_reg[ridx_reg[RIW-1:0]] &&
                       (!best_found_reg || (rt_rdata.cost > best_reg.cost));
    assign res_full  = (nres_reg >= NRW'(MAX_RESULTS));
    assign drop_nxt  = {1'b0, qidx_reg} + (QCW + 1)'(1);
    assign drop_more = (drop_nxt < {1'b0, wc_reg});

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.mode) inside
                        MODE_ADD:                 state_next = S_ADD_MUL;
                        MODE_FINISH:              state_next = S_RSCAN_RD;
                        MODE_PREEMPT, MODE_REMOVE: state_next = S_QSCAN_RD;
                        default:                  state_next = S_EMIT;
                    endcase
                end
            end
            S_ADD_MUL:  state_next = S_ADD_DEC;
            S_ADD_DEC:  state_next = S_EMIT;
            S_RSCAN_RD: state_next = (ridx_reg == RCW'(RUN_SLOTS)) ? S_EMIT : S_RSCAN_CK;
            S_RSCAN_CK: state_next = fin_hit ? S_EMIT : S_RSCAN_RD;
            S_HEAD_RD:
                state_next = ((wc_reg == '0) || res_full || !free_found) ? S_FLUSH : S_HEAD_CK;
            S_HEAD_CK:  state_next = head_fits ? S_DROP_RD : S_FLUSH;
            S_QSCAN_RD: state_next = (qidx_reg == wc_reg) ? S_EMIT : S_QSCAN_CK;
            S_QSCAN_CK:
            begin
                if (!q_hit)
                    state_next = S_QSCAN_RD;
                else if (req_reg.mode == MODE_REMOVE)
                    state_next = S_DROP_RD;
                else
                    state_next = S_PRE_CHK;
            end
            S_PRE_CHK:
            begin
                if (cand_over)
                    state_next = S_EMIT;
                else if (need_evict)
                    state_next = S_MAX_RD;
                else if (free_found && cand_fits)
                    state_next = S_DROP_RD;
                else
                    state_next = S_EMIT;
            end
            S_MAX_RD:   state_next = (ridx_reg == RCW'(RUN_SLOTS)) ? S_EVICT : S_MAX_CK;
            S_MAX_CK:   state_next = S_MAX_RD;
            S_EVICT:
                state_next = (nres_reg < NRW'(MAX_RESULTS - 1)) ? S_EMIT : S_PRE_CHK;
            S_DROP_RD:  state_next = drop_more ? S_DROP_WR : S_EMIT;
            S_DROP_WR:  state_next = S_DROP_RD;
            S_EMIT:
            begin
                if (res_full || em_stat.ack)
                    state_next = ret_reg;
            end
            S_FLUSH:    state_next = em_stat.ack ? S_IDLE : S_FLUSH;
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        req_next        = req_reg;
        prod_next       = prod_reg;
        mem_used_next   = mem_used_reg;
        units_used_next = units_used_reg;
        wc_next         = wc_reg;
        rc_next         = rc_reg;
        run_valid_next  = run_valid_reg;
        nres_next       = nres_reg;
        ridx_next       = ridx_reg;
        qidx_next       = qidx_reg;
        cand_next       = cand_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        em_kind_next    = em_kind_reg;
        em_task_next    = em_task_reg;
        ret_next        = ret_reg;
        rt_we           = 1'b0;
        rt_waddr        = free_idx;
        rt_wdata        = wq_rdata;
        wq_we           = 1'b0;
        wq_waddr        = qidx_reg[QIW-1:0];
        wq_wdata        = wq_rdata;
        wq_raddr        = qidx_reg[QIW-1:0];
        em_ctl.push     = 1'b0;
        em_ctl.flush    = 1'b0;

        em_ctl.word.kind          = em_kind_reg;
        em_ctl.word.result_task   = em_task_reg;
        em_ctl.word.free_memory   = (mem_cap_reg > mem_used_reg) ?
                                    (mem_cap_reg - mem_used_reg) : 20'd0;
        em_ctl.word.free_compute  = (cu_cap_reg > units_used_reg) ?
                                    (cu_cap_reg - units_used_reg) : 8'd0;
        em_ctl.word.pending_count = 5'(SUM_W'(wc_reg) + SUM_W'(rc_reg));
        em_ctl.word.last          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_next  = in_data;
                nres_next = '0;
                ridx_next = '0;
                qidx_next = '0;
                ret_next  = S_FLUSH;
                em_task_next = 16'd0;
                if (in_valid && (in_data.mode == MODE_CLEAR))
                begin
                    wc_next      = '0;
                    em_kind_next = KIND_CLEARED;
                end
                else
                    em_kind_next = KIND_STATUS;
            end
            S_ADD_MUL:
                prod_next = 36'(req_reg.data_size) * 36'(xfer_reg);
            S_ADD_DEC:
            begin
                em_task_next = req_reg.task_id;
                rt_wdata = '{ident: req_reg.task_id, memory: req_reg.data_size,
                             units: req_reg.compute_units, cost: add_cost};
                wq_wdata = rt_wdata;
                wq_waddr = wc_reg[QIW-1:0];
                if (add_bad)
                    em_kind_next = KIND_REJECTED;
                else if (add_start)
                begin
                    rt_we = 1'b1;
                    run_valid_next[free_idx] = 1'b1;
                    mem_used_next   = mem_used_reg + req_reg.data_size;
                    units_used_next = units_used_reg + req_reg.compute_units;
                    rc_next         = rc_reg + RCW'(1);
                    em_kind_next    = KIND_STARTED;
                end
                else if (!q_full)
                begin
                    wq_we        = 1'b1;
                    wc_next      = wc_reg + QCW'(1);
                    em_kind_next = KIND_QUEUED;
                end
                else
                    em_kind_next = KIND_FULL;
            end
            S_RSCAN_RD:
            begin
                em_kind_next = KIND_NOTFOUND;
                em_task_next = req_reg.task_id;
            end
            S_RSCAN_CK:
            begin
                if (fin_hit)
                begin
                    run_valid_next[ridx_reg[RIW-1:0]] = 1'b0;
                    mem_used_next   = mem_used_reg - rt_rdata.memory;
                    units_used_next = units_used_reg - rt_rdata.units;
                    rc_next         = rc_reg - RCW'(1);
                    em_kind_next    = KIND_FINISHED;
                    ret_next        = S_HEAD_RD;
                end
                else
                    ridx_next = ridx_reg + RCW'(1);
            end
            S_HEAD_RD:
            begin
                wq_raddr  = '0;
                qidx_next = '0;
            end
            S_HEAD_CK:
            begin
                if (head_fits)
                begin
                    rt_we = 1'b1;
                    rt_wdata = wq_rdata;
                    run_valid_next[free_idx] = 1'b1;
                    mem_used_next   = mem_used_reg + wq_rdata.memory;
                    units_used_next = units_used_reg + wq_rdata.units;
                    rc_next         = rc_reg + RCW'(1);
                    em_kind_next    = KIND_STARTED;
                    em_task_next    = wq_rdata.ident;
                    ret_next        = S_HEAD_RD;
                end
            end
            S_QSCAN_RD:
            begin
                em_kind_next = KIND_NOTFOUND;
                em_task_next = req_reg.task_id;
            end
            S_QSCAN_CK:
            begin
                if (q_hit)
                begin
                    cand_next    = wq_rdata;
                    em_kind_next = KIND_REMOVED;
                end
                else
                    qidx_next = qidx_reg + QCW'(1);
            end
            S_PRE_CHK:
            begin
                em_task_next    = req_reg.task_id;
                em_kind_next    = KIND_REJECTED;
                ret_next        = S_FLUSH;
                ridx_next       = '0;
                best_found_next = 1'b0;
                rt_wdata = '{ident: req_reg.task_id, memory: cand_reg.memory,
                             units: cand_reg.units, cost: cand_reg.cost};
                if (!cand_over && !need_evict && free_found && cand_fits)
                begin
                    rt_we = 1'b1;
                    run_valid_next[free_idx] = 1'b1;
                    mem_used_next   = mem_used_reg + cand_reg.memory;
                    units_used_next = units_used_reg + cand_reg.units;
                    rc_next         = rc_reg + RCW'(1);
                    em_kind_next    = KIND_STARTED;
                end
            end
            S_MAX_RD: ;
            S_MAX_CK:
            begin
                if (better)
                begin
                    best_next       = rt_rdata;
                    best_idx_next   = ridx_reg[RIW-1:0];
                    best_found_next = 1'b1;
                end
                ridx_next = ridx_reg + RCW'(1);
            end
            S_EVICT:
            begin
                run_valid_next[best_idx_reg] = 1'b0;
                mem_used_next   = mem_used_reg - best_reg.memory;
                units_used_next = units_used_reg - best_reg.units;
                rc_next         = rc_reg - RCW'(1);
                em_kind_next    = KIND_EVICTED;
                em_task_next    = best_reg.ident;
                ret_next        = S_PRE_CHK;
            end
            S_DROP_RD:
            begin
                wq_raddr = drop_nxt[QIW-1:0];
                if (!drop_more)
                    wc_next = wc_reg - QCW'(1);
            end
            S_DROP_WR:
            begin
                wq_we     = 1'b1;
                qidx_next = qidx_reg + QCW'(1);
            end
            S_EMIT:
            begin
                em_ctl.push = !res_full;
                if (!res_full && em_stat.ack)
                    nres_next = nres_reg + NRW'(1);
            end
            S_FLUSH:
                em_ctl.flush = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_FLUSH;
            mem_used_reg   <= '0;
            units_used_reg <= '0;
            wc_reg         <= '0;
            rc_reg         <= '0;
            run_valid_reg  <= '0;
            nres_reg       <= '0;
            ridx_reg       <= '0;
            qidx_reg       <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            mem_used_reg   <= mem_used_next;
            units_used_reg <= units_used_next;
            wc_reg         <= wc_next;
            rc_reg         <= rc_next;
            run_valid_reg  <= run_valid_next;
            nres_reg       <= nres_next;
            ridx_reg       <= ridx_next;
            qidx_reg       <= qidx_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        prod_reg     <= prod_next;
        cand_reg     <= cand_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        em_kind_reg  <= em_kind_next;
        em_task_reg  <= em_task_next;
    end

    // run table and wait queue: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (rt_we)
            rt_mem[rt_waddr] <= rt_wdata;
        rt_rdata <= rt_mem[ridx_reg[RIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wq_we)
            wq_mem[wq_waddr] <= wq_wdata;
        wq_rdata <= wq_mem[wq_raddr];
    end

    assign in_ready = (state_reg == S_IDLE);

    rta_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (em_ctl),
        .stat      (em_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[hw/rtl/rta_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_checker
// Port-level checks for the task admission block, bound to the top level.
// ----------------------------------------------------------------------------
module rta_checker
    import rta_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kind <= KIND_FULL)
        else $error("result kind out of range");

    // clear and status give a single result with no task
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_CLEARED || out_data.kind == KIND_STATUS)
        |-> out_data.last && (out_data.result_task == 16'd0))
        else $error("clear or status result malformed");

endmodule

bind resource_aware_task_admission rta_checker u_rta_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
